// ----- rtl/core/cmr_pkg.sv -----
// Package for the core-release mailbox register block.
// Holds the bank map, key values and request codes; depends on nothing.
package cmr_pkg;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [31:0] BANK_START = 32'h0000_0104;
    localparam logic [31:0] BANK_SPAN  = 32'h0000_000c;
    localparam logic [31:0] ARM_KEY    = 32'h0000_5500;
    localparam logic [31:0] DUMMY_BYTE = 32'h0000_0300;

    localparam logic [31:0] OFS_ENTRY   = 32'd0;
    localparam logic [31:0] OFS_RELEASE = 32'd4;
    localparam logic [31:0] OFS_ARM     = 32'd8;

    localparam logic [31:0] RELEASE_KEY = 32'd1;

    localparam int ADDR_W = 14;

endpackage

// ----- rtl/core/cmr_ram.sv -----
// Generic single-port synchronous RAM with a registered read port.
// Used for the byte lanes of the mailbox register block; no dependencies.
module cmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- rtl/core/core_release_mailbox_regs.sv -----
// Top level of the core-release mailbox register block.
// Depends on cmr_pkg and on cmr_ram for the four byte lanes.
//
// One bus access of 1 to 4 bytes is taken per clock while busy is low; its
// beat appears on the result ports with done high exactly one cycle later and
// must be taken then, since the receiver cannot stall it. The figure of one
// access per cycle comes from the four single-port byte-lane RAMs: every lane
// reads or writes one row per access. After reset, busy stays high for
// ceil(REGION_BYTES/4) cycles (2048 by default) while a clearing pass writes
// every row and sets byte 0x300 to one.
module core_release_mailbox_regs
    import cmr_pkg::*;
#(
    parameter int REGION_BYTES = 8192,
    parameter int NUM_BANKS    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [12:0] offset,
    input  logic [2:0]  access_size,
    input  logic [31:0] write_data,
    output logic        done,
    output logic [31:0] read_data,
    output logic        release_valid,
    output logic [1:0]  release_core,
    output logic [31:0] release_entry
);

    localparam int WORDS = (REGION_BYTES + 3) / 4;
    localparam int ROW_W = $clog2(WORDS);

    logic                 clear_reg, clear_next;
    logic [ROW_W-1:0]     clear_row_reg, clear_row_next;

    logic                 valid_reg;
    logic [1:0]           lo_reg;
    logic [3:0]           lane_mask_reg, lane_mask_next;
    logic                 rel_valid_reg, rel_valid_next;
    logic [1:0]           rel_core_reg, rel_core_next;
    logic [31:0]          rel_entry_reg, rel_entry_next;

    logic [NUM_BANKS-1:0] armed_reg, armed_next;
    logic [NUM_BANKS-1:0] ev_reg, ev_next;
    logic [31:0]          entry_reg [NUM_BANKS];
    logic [31:0]          entry_next [NUM_BANKS];

    logic                 accept;
    logic [2:0]           size_eff;
    logic [3:0]           lane_en;
    logic                 lane_we;
    logic [ROW_W-1:0]     lane_addr [4];
    logic [7:0]           lane_wdata [4];
    logic [7:0]           lane_q [4];
    logic [3:0]           lane_in;

    assign busy     = clear_reg;
    assign accept   = start && !clear_reg;
    assign size_eff = (access_size > 3'd4) ? 3'd4 : access_size;
    assign lane_we  = clear_reg || (req_type == REQ_WRITE);

    always_comb
    begin
        logic [1:0]        idx;
        logic [ADDR_W-1:0] a;
        logic [31:0]       shifted;
        for (int j = 0; j < 4; j++)
        begin
            idx = 2'(j) - offset[1:0];
            a = {1'b0, offset} + ADDR_W'(idx);
            lane_in[j] = ({1'b0, idx} < size_eff) && (32'(a) < 32'(REGION_BYTES));
            shifted = write_data >> {idx, 3'b000};
            lane_en[j] = clear_reg || (accept && lane_in[j]);
            if (clear_reg)
            begin
                lane_addr[j] = clear_row_reg;
                lane_wdata[j] = ((32'(clear_row_reg) == (DUMMY_BYTE >> 2))
                                 && (2'(j) == DUMMY_BYTE[1:0])) ? 8'd1 : 8'd0;
            end
            else
            begin
                lane_addr[j] = ROW_W'(a >> 2);
                lane_wdata[j] = shifted[7:0];
            end
            lane_mask_next[j] = lane_in[j] && (req_type == REQ_READ);
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        cmr_ram #(
            .WIDTH (8),
            .DEPTH (WORDS)
        ) u_ram (
            .clk   (clk),
            .en    (lane_en[g]),
            .we    (lane_we),
            .addr  (lane_addr[g]),
            .wdata (lane_wdata[g]),
            .rdata (lane_q[g])
        );
    end

    always_comb
    begin
        clear_next = clear_reg;
        clear_row_next = clear_row_reg;
        if (clear_reg)
        begin
            if (32'(clear_row_reg) == 32'(WORDS - 1))
            begin
                clear_next = 1'b0;
            end
            else
            begin
                clear_row_next = clear_row_reg + ROW_W'(1);
            end
        end
    end

    always_comb
    begin
        logic [31:0] base;
        logic [31:0] off32;
        logic [31:0] rel;
        logic        overlap;
        logic        full;
        armed_next = armed_reg;
        ev_next = ev_reg;
        entry_next = entry_reg;
        rel_valid_next = 1'b0;
        rel_core_next = 2'd0;
        rel_entry_next = 32'd0;
        off32 = 32'(offset);
        full = (size_eff == 3'd4) && (offset[1:0] == 2'd0);
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            base = BANK_START + 32'(b) * BANK_SPAN;
            rel = off32 - base;
            overlap = (off32 < base + BANK_SPAN) && (off32 + 32'(size_eff) > base);
            if (accept && (req_type == REQ_WRITE) && (size_eff != 3'd0) && overlap)
            begin
                if (!full)
                begin
                    armed_next[b] = 1'b0;
                    ev_next[b] = 1'b0;
                end
                else
                begin
                    case (rel)
                        OFS_ARM:
                        begin
                            armed_next[b] = (write_data == ARM_KEY);
                            ev_next[b] = 1'b0;
                        end
                        OFS_ENTRY:
                        begin
                            entry_next[b] = write_data;
                            ev_next[b] = armed_reg[b];
                        end
                        OFS_RELEASE:
                        begin
                            if ((write_data == RELEASE_KEY) && armed_reg[b] && ev_reg[b])
                            begin
                                rel_valid_next = 1'b1;
                                rel_core_next = 2'(b);
                                rel_entry_next = entry_reg[b];
                            end
                            armed_next[b] = 1'b0;
                            ev_next[b] = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= 1'b1;
            clear_row_reg <= '0;
            valid_reg <= 1'b0;
            lo_reg <= 2'd0;
            lane_mask_reg <= 4'd0;
            rel_valid_reg <= 1'b0;
            rel_core_reg <= 2'd0;
            rel_entry_reg <= 32'd0;
            armed_reg <= '0;
            ev_reg <= '0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                entry_reg[b] <= 32'd0;
            end
        end
        else
        begin
            clear_reg <= clear_next;
            clear_row_reg <= clear_row_next;
            valid_reg <= accept;
            armed_reg <= armed_next;
            ev_reg <= ev_next;
            entry_reg <= entry_next;
            if (accept)
            begin
                lo_reg <= offset[1:0];
                lane_mask_reg <= lane_mask_next;
                rel_valid_reg <= rel_valid_next;
                rel_core_reg <= rel_core_next;
                rel_entry_reg <= rel_entry_next;
            end
        end
    end

    always_comb
    begin
        logic [1:0] lane;
        for (int i = 0; i < 4; i++)
        begin
            lane = lo_reg + 2'(i);
            read_data[8*i +: 8] = lane_mask_reg[lane] ? lane_q[lane] : 8'd0;
        end
    end

    assign done          = valid_reg;
    assign release_valid = rel_valid_reg;
    assign release_core  = rel_core_reg;
    assign release_entry = rel_entry_reg;

endmodule

// ----- sim/core_release_mailbox_regs_checker.sv -----
// Checker for the core-release mailbox register block: watches the access and
// result ports, keeps a shadow of the byte store and bank flags, and compares
// every result beat with its prediction. Depends on cmr_pkg.
module core_release_mailbox_regs_checker
    import cmr_pkg::*;
#(
    parameter int REGION_BYTES = 8192,
    parameter int NUM_BANKS    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        req_type,
    input  logic [12:0] offset,
    input  logic [2:0]  access_size,
    input  logic [31:0] write_data,
    input  logic        done,
    input  logic [31:0] read_data,
    input  logic        release_valid,
    input  logic [1:0]  release_core,
    input  logic [31:0] release_entry,
    output int          fail_count,
    output int          outstanding
);

    typedef struct packed {
        logic [31:0] rdata;
        logic        rel_valid;
        logic [1:0]  rel_core;
        logic [31:0] rel_entry;
    } mailbox_result_t;

    logic [7:0]  shadow_bytes [REGION_BYTES];
    logic        shadow_armed [NUM_BANKS];
    logic        shadow_entry_ok [NUM_BANKS];
    logic [31:0] shadow_entry [NUM_BANKS];

    mailbox_result_t pending_results [$];

    function automatic mailbox_result_t predict_access(
        input logic        rq,
        input logic [12:0] ofs,
        input logic [2:0]  sz_in,
        input logic [31:0] wd
    );
        mailbox_result_t r;
        int sz;
        int a;
        int i;
        int b;
        int base;
        int rel_ofs;
        r = '0;
        sz = (sz_in > 3'd4) ? 4 : int'(sz_in);
        if (rq == REQ_READ)
        begin
            for (i = 0; i < sz; i++)
            begin
                a = int'(ofs) + i;
                if (a < REGION_BYTES)
                    r.rdata[8*i +: 8] = shadow_bytes[a];
            end
        end
        else if (sz != 0)
        begin
            for (i = 0; i < sz; i++)
            begin
                a = int'(ofs) + i;
                if (a < REGION_BYTES)
                    shadow_bytes[a] = wd[8*i +: 8];
            end
            for (b = 0; b < NUM_BANKS; b++)
            begin
                base = int'(BANK_START) + b * int'(BANK_SPAN);
                rel_ofs = int'(ofs) - base;
                if (int'(ofs) < base + int'(BANK_SPAN) && int'(ofs) + sz > base)
                begin
                    if (sz != 4 || ofs[1:0] != 2'b00)
                    begin
                        shadow_armed[b] = 1'b0;
                        shadow_entry_ok[b] = 1'b0;
                    end
                    else if (rel_ofs == int'(OFS_ARM))
                    begin
                        shadow_armed[b] = (wd == ARM_KEY);
                        shadow_entry_ok[b] = 1'b0;
                    end
                    else if (rel_ofs == int'(OFS_ENTRY))
                    begin
                        shadow_entry[b] = wd;
                        shadow_entry_ok[b] = shadow_armed[b];
                    end
                    else if (rel_ofs == int'(OFS_RELEASE))
                    begin
                        if (wd == RELEASE_KEY && shadow_armed[b] && shadow_entry_ok[b])
                        begin
                            r.rel_valid = 1'b1;
                            r.rel_core = b[1:0];
                            r.rel_entry = shadow_entry[b];
                        end
                        shadow_armed[b] = 1'b0;
                        shadow_entry_ok[b] = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        mailbox_result_t want;
        int k;
        int bad;
        if (!rst_n)
        begin
            for (k = 0; k < REGION_BYTES; k++)
                shadow_bytes[k] = 8'h00;
            if (int'(DUMMY_BYTE) < REGION_BYTES)
                shadow_bytes[int'(DUMMY_BYTE)] = 8'h01;
            for (k = 0; k < NUM_BANKS; k++)
            begin
                shadow_armed[k] = 1'b0;
                shadow_entry_ok[k] = 1'b0;
                shadow_entry[k] = 32'h0;
            end
            pending_results.delete();
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: read_data %h release %b/%0d/%h",
                             $time, read_data, release_valid, release_core, release_entry);
                    bad = 1;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (read_data !== want.rdata)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.rdata, read_data);
                        bad = 1;
                    end
                    if (release_valid !== want.rel_valid)
                    begin
                        $display("%0t: release_valid expected %b actual %b",
                                 $time, want.rel_valid, release_valid);
                        bad = 1;
                    end
                    if (release_core !== want.rel_core)
                    begin
                        $display("%0t: release_core expected %0d actual %0d",
                                 $time, want.rel_core, release_core);
                        bad = 1;
                    end
                    if (release_entry !== want.rel_entry)
                    begin
                        $display("%0t: release_entry expected %h actual %h",
                                 $time, want.rel_entry, release_entry);
                        bad = 1;
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(predict_access(req_type, offset, access_size,
                                                         write_data));
            if (bad != 0)
                fail_count <= fail_count + 1;
            outstanding <= pending_results.size();
        end
    end

endmodule

// ----- sim/core_release_mailbox_regs_tb.sv -----
// Testbench top for the core-release mailbox register block: drives directed
// and random bus accesses and gives the verdict.
// Depends on cmr_pkg, core_release_mailbox_regs and core_release_mailbox_regs_checker.
module core_release_mailbox_regs_tb;
    import cmr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        req_type;
    logic [12:0] offset;
    logic [2:0]  access_size;
    logic [31:0] write_data;
    logic        done;
    logic [31:0] read_data;
    logic        release_valid;
    logic [1:0]  release_core;
    logic [31:0] release_entry;
    int          fail_count;
    int          outstanding;

    int accesses_sent;
    int no_idle_left;

    core_release_mailbox_regs u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .offset        (offset),
        .access_size   (access_size),
        .write_data    (write_data),
        .done          (done),
        .read_data     (read_data),
        .release_valid (release_valid),
        .release_core  (release_core),
        .release_entry (release_entry)
    );

    core_release_mailbox_regs_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .offset        (offset),
        .access_size   (access_size),
        .write_data    (write_data),
        .done          (done),
        .read_data     (read_data),
        .release_valid (release_valid),
        .release_core  (release_core),
        .release_entry (release_entry),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic [12:0] bank_reg(input int b, input logic [31:0] reg_ofs);
        return 13'(int'(BANK_START) + b * int'(BANK_SPAN) + int'(reg_ofs));
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic issue_access(
        input logic        rq,
        input logic [12:0] ofs,
        input logic [2:0]  sz,
        input logic [31:0] wd
    );
        int gap;
        int roll;
        gap = 0;
        if (no_idle_left > 0)
            no_idle_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                no_idle_left = $urandom_range(20, 80);
            else if (roll < 50)
                gap = 0;
            else if (roll < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= rq;
        offset <= ofs;
        access_size <= sz;
        write_data <= wd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        accesses_sent++;
        @(negedge clk);
    endtask

    task automatic run_release_sequence(input int b);
        logic [31:0] key;
        key = ($urandom_range(0, 9) < 8) ? ARM_KEY : 32'($urandom);
        if ($urandom_range(0, 6) == 0)
            issue_access(REQ_WRITE, bank_reg(b, OFS_ENTRY), 3'd4, $urandom);
        issue_access(REQ_WRITE, bank_reg(b, OFS_ARM), 3'd4, key);
        if ($urandom_range(0, 9) == 0)
            issue_access(REQ_WRITE, bank_reg(b, 32'($urandom_range(0, 11))),
                         3'($urandom_range(0, 7)), $urandom);
        if ($urandom_range(0, 7) == 0)
            issue_access(REQ_WRITE, bank_reg($urandom_range(0, 3), OFS_ARM), 3'd4, ARM_KEY);
        issue_access(REQ_WRITE, bank_reg(b, OFS_ENTRY), 3'd4, $urandom);
        if ($urandom_range(0, 4) == 0)
            issue_access(REQ_READ, bank_reg(b, 32'($urandom_range(0, 11))),
                         3'($urandom_range(0, 7)), $urandom);
        if ($urandom_range(0, 9) == 0)
            issue_access(REQ_WRITE, bank_reg(b, OFS_ARM), 3'd4, $urandom);
        issue_access(REQ_WRITE, bank_reg(b, OFS_RELEASE), 3'd4,
                     ($urandom_range(0, 9) < 8) ? RELEASE_KEY : 32'($urandom));
    endtask

    initial
    begin
        int roll;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_READ;
        offset = 13'h0;
        access_size = 3'd0;
        write_data = 32'h0;
        accesses_sent = 0;
        no_idle_left = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue_access(REQ_READ, 13'(DUMMY_BYTE), 3'd4, 32'h0);
        issue_access(REQ_READ, 13'h1ffe, 3'd4, 32'hffff_ffff);
        issue_access(REQ_WRITE, 13'h1ffe, 3'd4, 32'ha5a5_5a5a);
        issue_access(REQ_READ, 13'h1ffc, 3'd4, 32'h0);
        issue_access(REQ_READ, 13'h1fff, 3'd1, 32'h0);
        issue_access(REQ_WRITE, bank_reg(0, OFS_ARM), 3'd4, ARM_KEY);
        issue_access(REQ_WRITE, bank_reg(0, OFS_ENTRY), 3'd4, 32'hdead_beef);
        issue_access(REQ_WRITE, bank_reg(0, OFS_RELEASE), 3'd4, RELEASE_KEY);
        issue_access(REQ_WRITE, bank_reg(0, OFS_RELEASE), 3'd4, RELEASE_KEY);
        issue_access(REQ_WRITE, bank_reg(3, OFS_ARM), 3'd4, ARM_KEY);
        issue_access(REQ_WRITE, bank_reg(3, OFS_ENTRY), 3'd4, 32'h8000_0000);
        issue_access(REQ_WRITE, bank_reg(3, 32'd2), 3'd2, 32'h0000_1234);
        issue_access(REQ_WRITE, bank_reg(3, OFS_RELEASE), 3'd4, RELEASE_KEY);
        issue_access(REQ_WRITE, bank_reg(1, OFS_ENTRY), 3'd4, 32'h1234_5678);
        issue_access(REQ_WRITE, bank_reg(1, OFS_ARM), 3'd4, ARM_KEY);
        issue_access(REQ_WRITE, bank_reg(1, OFS_RELEASE), 3'd4, RELEASE_KEY);
        issue_access(REQ_WRITE, bank_reg(2, OFS_ARM), 3'd4, ARM_KEY ^ 32'h1);
        issue_access(REQ_WRITE, bank_reg(2, OFS_ENTRY), 3'd4, 32'hffff_ffff);
        issue_access(REQ_WRITE, bank_reg(2, OFS_ARM), 3'd4, ARM_KEY);
        issue_access(REQ_WRITE, bank_reg(2, OFS_ENTRY), 3'd4, 32'hffff_ffff);
        issue_access(REQ_WRITE, bank_reg(2, OFS_RELEASE), 3'd4, 32'h0000_0002);
        issue_access(REQ_WRITE, bank_reg(0, OFS_ENTRY), 3'd0, 32'hffff_ffff);
        issue_access(REQ_WRITE, bank_reg(0, 32'd1), 3'd4, 32'h0102_0304);
        issue_access(REQ_READ, bank_reg(0, OFS_ENTRY), 3'd7, 32'h0);
        issue_access(REQ_READ, 13'h0, 3'd0, 32'h0);

        while (accesses_sent < 1450)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                run_release_sequence($urandom_range(0, 3));
            else if (roll < 75)
                issue_access(1'($urandom_range(0, 1)), 13'($urandom_range(32'h100, 32'h138)),
                             3'($urandom_range(0, 7)), $urandom);
            else if (roll < 90)
                issue_access(1'($urandom_range(0, 1)), 13'($urandom),
                             3'($urandom_range(0, 7)), $urandom);
            else if (roll < 95)
                issue_access(1'($urandom_range(0, 1)), 13'($urandom_range(32'h1ff8, 32'h1fff)),
                             3'($urandom_range(0, 7)), $urandom);
            else
                issue_access(1'($urandom_range(0, 1)), 13'($urandom_range(32'h2fc, 32'h303)),
                             3'($urandom_range(0, 7)), $urandom);
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- core_release_mailbox_regs.f -----
rtl/core/cmr_pkg.sv
rtl/core/cmr_ram.sv
rtl/core/core_release_mailbox_regs.sv
sim/core_release_mailbox_regs_checker.sv
sim/core_release_mailbox_regs_tb.sv
